### rtl/ifp_pkg.sv
// Shared types, constants and datapath command codes for the indexed framebuffer palette unit.
package ifp_pkg;

    // Storage sizes
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam int USED_W      = $clog2(PAL_ENTRIES + 1);
    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 256;
    localparam int PIX_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_AW      = $clog2(PIX_DEPTH);

    typedef logic [PIX_AW-1:0] pix_addr_t;
    typedef logic [USED_W-1:0] used_t;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd2;

    localparam logic [9:0]  RST_WIDTH  = 10'd320;
    localparam logic [8:0]  RST_HEIGHT = 9'd240;
    localparam logic [15:0] RST_MASK   = 16'hFFFF;

    // Item commands
    localparam logic [2:0] CMD_PIXEL = 3'd0;
    localparam logic [2:0] CMD_HRUN  = 3'd1;
    localparam logic [2:0] CMD_VRUN  = 3'd2;
    localparam logic [2:0] CMD_FLUSH = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Datapath operations issued by the controller
    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR    = 4'd1;
    localparam logic [OP_W-1:0] OP_LOAD     = 4'd2;
    localparam logic [OP_W-1:0] OP_SRCH_RD  = 4'd3;
    localparam logic [OP_W-1:0] OP_SRCH_CMP = 4'd4;
    localparam logic [OP_W-1:0] OP_ALLOC    = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL      = 4'd6;
    localparam logic [OP_W-1:0] OP_BASE     = 4'd7;
    localparam logic [OP_W-1:0] OP_WRITE    = 4'd8;
    localparam logic [OP_W-1:0] OP_FL_CHK   = 4'd9;
    localparam logic [OP_W-1:0] OP_FL_PAL   = 4'd10;
    localparam logic [OP_W-1:0] OP_FL_OUT   = 4'd11;
    localparam logic [OP_W-1:0] OP_RD_SLOT  = 4'd12;
    localparam logic [OP_W-1:0] OP_RD_OUT   = 4'd13;
    localparam logic [OP_W-1:0] OP_EMIT     = 4'd14;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [8:0]  pos_x;
        logic [7:0]  pos_y;
        logic [9:0]  run_length;
        logic [15:0] pixel_color;
        logic [7:0]  palette_slot;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  assigned_index;
        logic        palette_full;
        logic [15:0] out_color;
        logic        frame_last;
    } out_item_t;

    typedef struct packed {
        logic clr_done;
        logic srch_end;
        logic match;
        logic run_go;
        logic is_flush;
        logic out_free;
    } status_t;

endpackage

### rtl/ifp_ctrl.sv
// Controller state machine: sequences clearing, palette search, run writes, flush and read.
module ifp_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  logic [2:0]               item_cmd,
    input  ifp_pkg::status_t         status,
    output logic [ifp_pkg::OP_W-1:0] op
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SRCH_RD  = 4'd2;
    localparam logic [3:0] S_SRCH_CMP = 4'd3;
    localparam logic [3:0] S_ALLOC    = 4'd4;
    localparam logic [3:0] S_MUL      = 4'd5;
    localparam logic [3:0] S_BASE     = 4'd6;
    localparam logic [3:0] S_WRITE    = 4'd7;
    localparam logic [3:0] S_FL_CHK   = 4'd8;
    localparam logic [3:0] S_FL_PAL   = 4'd9;
    localparam logic [3:0] S_FL_OUT   = 4'd10;
    localparam logic [3:0] S_RD_SLOT  = 4'd11;
    localparam logic [3:0] S_RD_OUT   = 4'd12;
    localparam logic [3:0] S_EMIT     = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = ifp_pkg::OP_NONE;
        cmd_stall  = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                op = ifp_pkg::OP_CLEAR;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    op = ifp_pkg::OP_LOAD;
                    unique case (item_cmd)
                        ifp_pkg::CMD_PIXEL, ifp_pkg::CMD_HRUN, ifp_pkg::CMD_VRUN:
                            state_next = S_SRCH_RD;
                        ifp_pkg::CMD_FLUSH:
                            state_next = S_MUL;
                        ifp_pkg::CMD_READ:
                            state_next = S_RD_SLOT;
                        default:
                            state_next = S_EMIT;
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                if (status.srch_end)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    op         = ifp_pkg::OP_SRCH_RD;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                op         = ifp_pkg::OP_SRCH_CMP;
                state_next = status.match ? S_MUL : S_SRCH_RD;
            end
            S_ALLOC:
            begin
                op         = ifp_pkg::OP_ALLOC;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                op         = ifp_pkg::OP_MUL;
                state_next = status.is_flush ? S_FL_CHK : S_BASE;
            end
            S_BASE:
            begin
                op         = ifp_pkg::OP_BASE;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // write one pixel per cycle until the run ends or leaves the canvas
                if (status.run_go)
                begin
                    op = ifp_pkg::OP_WRITE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_FL_CHK:
            begin
                op         = ifp_pkg::OP_FL_CHK;
                state_next = S_FL_PAL;
            end
            S_FL_PAL:
            begin
                op         = ifp_pkg::OP_FL_PAL;
                state_next = S_FL_OUT;
            end
            S_FL_OUT:
            begin
                op         = ifp_pkg::OP_FL_OUT;
                state_next = S_EMIT;
            end
            S_RD_SLOT:
            begin
                op         = ifp_pkg::OP_RD_SLOT;
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                op         = ifp_pkg::OP_RD_OUT;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    op         = ifp_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/ifp_datapath.sv
// Datapath: configuration, item and result registers, palette and pixel memories, output register.
module ifp_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ifp_pkg::OP_W-1:0]      op,
    output ifp_pkg::status_t              status,
    input  ifp_pkg::in_item_t             cmd_item,
    input  logic                          cfg_wr_en,
    input  logic [ifp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ifp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                          res_valid,
    input  logic                          res_stall,
    output ifp_pkg::out_item_t            res_item
);

    // Configuration
    logic [9:0]  width_reg;
    logic [8:0]  height_reg;
    logic [15:0] mask_reg;
    logic [9:0]  w_eff;
    logic [8:0]  h_eff;

    // Current item
    logic [2:0]  cmd_reg;
    logic [8:0]  x_reg;
    logic [7:0]  y_reg;
    logic [9:0]  len_reg;
    logic [15:0] color_reg;
    logic [7:0]  slot_reg;

    // Result under construction
    logic [7:0]  idx_reg;
    logic        full_reg;
    logic [15:0] ocol_reg;
    logic        last_reg;

    // Working registers
    logic [9:0]         cnt_reg;
    ifp_pkg::used_t     used_reg;
    ifp_pkg::pix_addr_t scan_reg;
    ifp_pkg::pix_addr_t clr_reg;
    ifp_pkg::pix_addr_t addr_reg;
    logic [18:0]        mul_reg;
    logic [10:0]        px_reg;
    logic [9:0]         py_reg;

    logic               res_valid_reg;
    ifp_pkg::out_item_t res_item_reg;

    // Memories
    logic [15:0] pal_mem [ifp_pkg::PAL_ENTRIES];
    logic [15:0] pal_rd_data;
    logic [ifp_pkg::PAL_AW-1:0] pal_rd_addr;
    logic [7:0]  pix_mem [ifp_pkg::PIX_DEPTH];
    logic [7:0]  pix_rd_data;

    logic [8:0]         mul_b;
    logic [18:0]        base_sum;
    ifp_pkg::pix_addr_t eff_addr;
    ifp_pkg::pix_addr_t addr_step;
    logic               scan_last;
    logic               used_below;
    logic               run_len_ok;
    logic               in_canvas;
    logic               res_take;

    // Clamp canvas size: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        priority if (width_reg == 10'd0)
            w_eff = 10'd1;
        else if (32'(width_reg) > ifp_pkg::MAX_WIDTH)
            w_eff = 10'(ifp_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;

        priority if (height_reg == 9'd0)
            h_eff = 9'd1;
        else if (32'(height_reg) > ifp_pkg::MAX_HEIGHT)
            h_eff = 9'(ifp_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign mul_b      = (cmd_reg == ifp_pkg::CMD_FLUSH) ? h_eff : {1'b0, y_reg};
    assign base_sum   = mul_reg + 19'(x_reg);
    // restart the scan when the canvas has shrunk below the pointer
    assign eff_addr   = (19'(scan_reg) >= mul_reg) ? '0 : scan_reg;
    assign scan_last  = (19'(scan_reg) == (mul_reg - 19'd1));
    assign addr_step  = (cmd_reg == ifp_pkg::CMD_VRUN) ? ifp_pkg::pix_addr_t'(w_eff)
                                                      : ifp_pkg::pix_addr_t'(1);
    assign used_below = (32'(used_reg) < ifp_pkg::PAL_ENTRIES);
    assign run_len_ok = (cmd_reg == ifp_pkg::CMD_PIXEL) ? (cnt_reg == 10'd0)
                                                        : (cnt_reg < len_reg);
    assign in_canvas  = (px_reg < 11'(w_eff)) && (py_reg < 10'(h_eff));
    assign res_take   = res_valid_reg && !res_stall;

    always_comb
    begin
        status.clr_done = (clr_reg == ifp_pkg::pix_addr_t'(ifp_pkg::PIX_DEPTH - 1));
        status.srch_end = (32'(cnt_reg) >= 32'(used_reg));
        status.match    = (pal_rd_data == color_reg);
        status.run_go   = run_len_ok && in_canvas;
        status.is_flush = (cmd_reg == ifp_pkg::CMD_FLUSH);
        status.out_free = !res_valid_reg || !res_stall;
    end

    always_comb
    begin
        unique case (op)
            ifp_pkg::OP_FL_PAL:  pal_rd_addr = pix_rd_data[ifp_pkg::PAL_AW-1:0];
            ifp_pkg::OP_RD_SLOT: pal_rd_addr = slot_reg[ifp_pkg::PAL_AW-1:0];
            default:             pal_rd_addr = cnt_reg[ifp_pkg::PAL_AW-1:0];
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= ifp_pkg::RST_WIDTH;
            height_reg    <= ifp_pkg::RST_HEIGHT;
            mask_reg      <= ifp_pkg::RST_MASK;
            used_reg      <= '0;
            scan_reg      <= '0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    ifp_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[9:0];
                    ifp_pkg::CFG_HEIGHT: height_reg <= cfg_wdata[8:0];
                    ifp_pkg::CFG_MASK:   mask_reg   <= cfg_wdata[15:0];
                    default:             ;
                endcase
            end

            if (op == ifp_pkg::OP_CLEAR)
            begin
                clr_reg <= clr_reg + ifp_pkg::pix_addr_t'(1);
            end

            if ((op == ifp_pkg::OP_ALLOC) && used_below)
            begin
                used_reg <= used_reg + ifp_pkg::used_t'(1);
            end

            if (op == ifp_pkg::OP_FL_CHK)
            begin
                scan_reg <= eff_addr;
            end
            else if (op == ifp_pkg::OP_FL_OUT)
            begin
                scan_reg <= scan_last ? '0 : scan_reg + ifp_pkg::pix_addr_t'(1);
            end

            if (op == ifp_pkg::OP_EMIT)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        unique case (op)
            ifp_pkg::OP_LOAD:
            begin
                cmd_reg   <= cmd_item.cmd;
                x_reg     <= cmd_item.pos_x;
                y_reg     <= cmd_item.pos_y;
                len_reg   <= cmd_item.run_length;
                color_reg <= cmd_item.pixel_color & mask_reg;
                slot_reg  <= cmd_item.palette_slot;
                idx_reg   <= 8'd0;
                full_reg  <= 1'b0;
                ocol_reg  <= 16'd0;
                last_reg  <= 1'b0;
                cnt_reg   <= 10'd0;
            end
            ifp_pkg::OP_SRCH_CMP:
            begin
                if (status.match)
                begin
                    idx_reg <= 8'(cnt_reg);
                end
                else
                begin
                    cnt_reg <= cnt_reg + 10'd1;
                end
            end
            ifp_pkg::OP_ALLOC:
            begin
                if (used_below)
                begin
                    idx_reg <= 8'(used_reg);
                end
                else
                begin
                    // palette full: fall back to entry zero
                    full_reg <= 1'b1;
                    idx_reg  <= 8'd0;
                end
            end
            ifp_pkg::OP_MUL:
            begin
                mul_reg <= 19'(w_eff) * 19'(mul_b);
            end
            ifp_pkg::OP_BASE:
            begin
                addr_reg <= ifp_pkg::pix_addr_t'(base_sum);
                px_reg   <= 11'(x_reg);
                py_reg   <= 10'(y_reg);
                cnt_reg  <= 10'd0;
            end
            ifp_pkg::OP_WRITE:
            begin
                addr_reg <= addr_reg + addr_step;
                cnt_reg  <= cnt_reg + 10'd1;
                if (cmd_reg == ifp_pkg::CMD_VRUN)
                begin
                    py_reg <= py_reg + 10'd1;
                end
                else
                begin
                    px_reg <= px_reg + 11'd1;
                end
            end
            ifp_pkg::OP_FL_PAL:
            begin
                idx_reg <= pix_rd_data;
            end
            ifp_pkg::OP_FL_OUT:
            begin
                // entries beyond the fill count were never written and read as zero
                ocol_reg <= (32'(idx_reg) < 32'(used_reg)) ? pal_rd_data : 16'd0;
                last_reg <= scan_last;
            end
            ifp_pkg::OP_RD_SLOT:
            begin
                idx_reg <= slot_reg;
            end
            ifp_pkg::OP_RD_OUT:
            begin
                ocol_reg <= (32'(slot_reg) < 32'(used_reg)) ? pal_rd_data : 16'd0;
            end
            ifp_pkg::OP_EMIT:
            begin
                res_item_reg.assigned_index <= idx_reg;
                res_item_reg.palette_full   <= full_reg;
                res_item_reg.out_color      <= ocol_reg;
                res_item_reg.frame_last     <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if ((op == ifp_pkg::OP_ALLOC) && used_below)
        begin
            pal_mem[used_reg[ifp_pkg::PAL_AW-1:0]] <= color_reg;
        end
        pal_rd_data <= pal_mem[pal_rd_addr];
    end

    // Pixel memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (op == ifp_pkg::OP_CLEAR)
        begin
            pix_mem[clr_reg] <= 8'd0;
        end
        else if (op == ifp_pkg::OP_WRITE)
        begin
            pix_mem[addr_reg] <= idx_reg;
        end

        if (op == ifp_pkg::OP_FL_CHK)
        begin
            pix_rd_data <= pix_mem[eff_addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

### rtl/indexed_framebuffer_palette_unit.sv
// Top level of the indexed framebuffer with self-filling palette.
//
//   Channel   Signals                          Payload
//   -------   ------------------------------   -----------------------------------
//   command   cmd_valid / cmd_stall            cmd_item (ifp_pkg::in_item_t)
//   result    res_valid / res_stall            res_item (ifp_pkg::out_item_t)
//   config    cfg_wr_en, cfg_index, cfg_wdata  width, height, color mask
//
// One item at a time. Draw, new color: palette scan over U used entries, a new entry
// if the palette has room, then N pixel writes up to the clipped run length; draw,
// color found at the S-th entry: the scan stops there. Flush: multiply, pixel read,
// palette read. Read: palette read of the slot. Other commands: result only.
// After reset a clearing pass writes zero to all 131072 pixel entries, one per
// cycle, with cmd_stall high. Results sit in an output register; the next item is
// taken while a result waits there, and its own result holds the block in its
// final step until the waiting one leaves.
module indexed_framebuffer_palette_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  ifp_pkg::in_item_t              cmd_item,
    output logic                           res_valid,
    input  logic                           res_stall,
    output ifp_pkg::out_item_t             res_item,
    input  logic                           cfg_wr_en,
    input  logic [ifp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ifp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic [ifp_pkg::OP_W-1:0] op;
    ifp_pkg::status_t         status;

    ifp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .item_cmd  (cmd_item.cmd),
        .status    (status),
        .op        (op)
    );

    ifp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .cmd_item  (cmd_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
